// ===== rtl/task_state_list_manager_assert.svh =====
// assertion macros shared by the task state list manager rtl
`ifndef TASK_STATE_LIST_MANAGER_ASSERT_SVH
`define TASK_STATE_LIST_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define TSLM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define TSLM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define TSLM_ASSERT(lbl, prop, msg)
`define TSLM_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tslm_pkg.sv =====
// shared constants, codes and types of the task state list manager
`default_nettype none
package tslm_pkg;

	localparam int NUM_TASKS  = 16;
	localparam int NUM_STATES = 4;

	localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int ST_W   = $clog2(NUM_STATES);
	localparam int CNT_W  = $clog2(NUM_TASKS + 1);

	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 5;
	localparam int RC_W     = 2;
	localparam int HEAD_W   = 4;
	localparam int COUNT_W  = 5;

	localparam logic [FUNC_W-1:0] FUNC_HEAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd2;

	localparam logic [RC_W-1:0] RC_OK         = 2'd0;
	localparam logic [RC_W-1:0] RC_EMPTY      = 2'd1;
	localparam logic [RC_W-1:0] RC_BAD_STATUS = 2'd2;
	localparam logic [RC_W-1:0] RC_BAD_SLOT   = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [RC_W-1:0]    code;
		logic [HEAD_W-1:0]  head;
		logic [COUNT_W-1:0] count;
		logic               empty;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/tslm_lists.sv =====
// linked list state of the slot pool and the single pass command logic
`default_nettype none
module tslm_lists import tslm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output rsp_t      rsp
);

	logic [ST_W-1:0]   status_q [NUM_TASKS];
	logic [SLOT_W-1:0] next_q   [NUM_TASKS];
	logic [SLOT_W-1:0] prev_q   [NUM_TASKS];
	logic [SLOT_W-1:0] head_q   [NUM_STATES];
	logic [SLOT_W-1:0] tail_q   [NUM_STATES];
	logic [CNT_W-1:0]  size_q   [NUM_STATES];

	logic [ST_W-1:0]   status_d [NUM_TASKS];
	logic [SLOT_W-1:0] next_d   [NUM_TASKS];
	logic [SLOT_W-1:0] prev_d   [NUM_TASKS];
	logic [SLOT_W-1:0] head_d   [NUM_STATES];
	logic [SLOT_W-1:0] tail_d   [NUM_STATES];
	logic [CNT_W-1:0]  size_d   [NUM_STATES];

	logic                   st_ok;
	logic                   slot_ok;
	logic                   do_move;
	logic [ST_W-1:0]        t;
	logic [SLOT_W-1:0]      s;
	logic [SLOT_W+INDEX_W-1:0] slot_ext;
	logic [ST_W-1:0]        cur;
	logic [SLOT_W-1:0]      p;
	logic [SLOT_W-1:0]      n;
	logic [SLOT_W-1:0]      tl;
	logic                   is_head;
	logic                   is_tail;
	logic [CNT_W-1:0]       cnt;
	logic [HEAD_W+SLOT_W-1:0]  head_ext;
	logic [COUNT_W+CNT_W-1:0]  cnt_ext;

	// decode and index selection
	always_comb begin
		st_ok    = ({{(32-STATUS_W){1'b0}}, cmd.status} < 32'(NUM_STATES));
		slot_ok  = ({{(32-INDEX_W){1'b0}}, cmd.slot} < 32'(NUM_TASKS));
		t        = cmd.status[ST_W-1:0];
		slot_ext = {{SLOT_W{1'b0}}, cmd.slot};
		s        = slot_ext[SLOT_W-1:0];
		do_move  = cmd_valid && (cmd.func == FUNC_MOVE) && st_ok && slot_ok;
		cur      = status_q[s];
		p        = prev_q[s];
		n        = next_q[s];
		is_head  = (head_q[cur] == s);
		is_tail  = (tail_q[cur] == s);
	end

	// move: unlink from the current list, then append at the tail of the target
	always_comb begin
		status_d = status_q;
		next_d   = next_q;
		prev_d   = prev_q;
		head_d   = head_q;
		tail_d   = tail_q;
		size_d   = size_q;
		tl       = '0;
		if (do_move) begin
			if (is_head) begin
				head_d[cur] = n;
			end else begin
				next_d[p] = n;
			end
			if (is_tail) begin
				tail_d[cur] = p;
			end else begin
				prev_d[n] = p;
			end
			if (size_d[cur] != '0) begin
				size_d[cur] = size_d[cur] - CNT_W'(1);
			end
			if (size_d[t] == '0) begin
				head_d[t] = s;
				prev_d[s] = s;
			end else begin
				tl         = tail_d[t];
				next_d[tl] = s;
				prev_d[s]  = tl;
			end
			next_d[s]   = s;
			tail_d[t]   = s;
			size_d[t]   = size_d[t] + CNT_W'(1);
			status_d[s] = t;
		end
	end

	// response fields
	always_comb begin
		cnt       = size_d[t];
		head_ext  = {{HEAD_W{1'b0}}, head_q[t]};
		cnt_ext   = {{COUNT_W{1'b0}}, cnt};
		rsp       = '0;
		if (cmd.func == FUNC_HEAD || cmd.func == FUNC_QUERY || cmd.func == FUNC_MOVE) begin
			if (!st_ok) begin
				rsp.code = RC_BAD_STATUS;
			end else if (cmd.func == FUNC_MOVE && !slot_ok) begin
				rsp.code = RC_BAD_SLOT;
			end else if (cmd.func == FUNC_HEAD && cnt == '0) begin
				rsp.code  = RC_EMPTY;
				rsp.empty = 1'b1;
			end else begin
				rsp.code  = RC_OK;
				rsp.count = cnt_ext[COUNT_W-1:0];
				rsp.empty = (cnt == '0);
				if (cmd.func == FUNC_HEAD) begin
					rsp.head = head_ext[HEAD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				status_q[i] <= '0;
				next_q[i]   <= (i + 1 < NUM_TASKS) ? SLOT_W'(i + 1) : '0;
				prev_q[i]   <= (i > 0) ? SLOT_W'(i - 1) : '0;
			end
			for (int j = 0; j < NUM_STATES; j++) begin
				head_q[j] <= '0;
				tail_q[j] <= (j == 0) ? SLOT_W'(NUM_TASKS - 1) : '0;
				size_q[j] <= (j == 0) ? CNT_W'(NUM_TASKS) : '0;
			end
		end else if (do_move) begin
			status_q <= status_d;
			next_q   <= next_d;
			prev_q   <= prev_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			size_q   <= size_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/task_state_list_manager.sv =====
// top level of the task state list manager: command register, list logic, result register
// a command passes the command register, then the result register, which raises done
// throughput: one command per cycle, busy stays low; each command finishes in
// one pass through the list logic between the command and result registers
// the receiver cannot stall: done is high for exactly one cycle per item
// reset (arst_n low, asynchronous): all slots in the idle list in index order
`default_nettype none
`include "task_state_list_manager_assert.svh"
module task_state_list_manager import tslm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [STATUS_W-1:0] list_status,
	input  wire logic [INDEX_W-1:0]  slot_index,
	output logic                     done,
	output logic [RC_W-1:0]          result_code,
	output logic [HEAD_W-1:0]        head_slot,
	output logic [COUNT_W-1:0]       list_count,
	output logic                     empty_flag
);

	// command register
	logic valid_s1;
	cmd_t cmd_s1;

	// result register
	logic done_q;
	rsp_t rsp_q;

	rsp_t rsp;

	// every cycle can take an item, since the list update completes in one pass
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// payload registers need no reset
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= '{func: func, status: list_status, slot: slot_index};
		end
	end

	// list state lives here; it is updated at the edge that loads the result
	tslm_lists u_lists (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (valid_s1),
		.cmd       (cmd_s1),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp;
		end
	end

	assign done        = done_q;
	assign result_code = rsp_q.code;
	assign head_slot   = rsp_q.head;
	assign list_count  = rsp_q.count;
	assign empty_flag  = rsp_q.empty;

	// a strobe always comes from a command held in the command register
	`TSLM_ASSERT(a_done_from_cmd, done |-> $past(valid_s1), "result strobe without a command")
	// every accepted item gives a strobe once it has passed the command and result registers
	`TSLM_ASSERT(a_item_result, (start && !busy) |=> ##1 done, "accepted item gave no result")
	// an empty list never reports a count or a head
	`TSLM_ASSERT_IMPL(a_empty_fields, done && empty_flag, list_count == '0 && head_slot == '0, "empty result carries a count or head")
	// errors leave every other field clear
	`TSLM_ASSERT_IMPL(a_error_fields, done && (result_code == RC_BAD_STATUS || result_code == RC_BAD_SLOT), list_count == '0 && head_slot == '0 && !empty_flag, "error result carries data")

endmodule
`default_nettype wire

// ===== tb/sv/task_state_list_manager_tb.sv =====
// self-checking testbench for the task state list manager: shadow lists, directed and random items
`default_nettype none
module task_state_list_manager_tb import tslm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// the package names no code for the fourth func value, which the block ignores
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 10;

	// shadow copy of the slot lists; predicts each reply and checks the block against it
	class slot_list_shadow;
		logic [ST_W-1:0]   slot_state [NUM_TASKS];
		logic [SLOT_W-1:0] next_slot  [NUM_TASKS];
		logic [SLOT_W-1:0] prev_slot  [NUM_TASKS];
		logic [SLOT_W-1:0] head_of    [NUM_STATES];
		logic [SLOT_W-1:0] tail_of    [NUM_STATES];
		logic [CNT_W-1:0]  size_of    [NUM_STATES];
		rsp_t pending_replies [$];
		int mismatches;

		function new();
			mismatches = 0;
			// after reset every slot is idle, chained in index order
			for (int i = 0; i < NUM_TASKS; i++) begin
				slot_state[i] = '0;
				next_slot[i] = (i + 1 < NUM_TASKS) ? SLOT_W'(i + 1) : '0;
				prev_slot[i] = (i > 0) ? SLOT_W'(i - 1) : '0;
			end
			for (int s = 0; s < NUM_STATES; s++) begin
				head_of[s] = '0;
				tail_of[s] = '0;
				size_of[s] = '0;
			end
			tail_of[0] = SLOT_W'(NUM_TASKS - 1);
			size_of[0] = CNT_W'(NUM_TASKS);
		endfunction

		// unlink a slot from its list and append it to the tail of the target list
		function void relink(int s, int t);
			int cur;
			int p;
			int n;
			cur = slot_state[s];
			p = prev_slot[s];
			n = next_slot[s];
			if (head_of[cur] == s) head_of[cur] = SLOT_W'(n);
			else next_slot[p] = SLOT_W'(n);
			if (tail_of[cur] == s) tail_of[cur] = SLOT_W'(p);
			else prev_slot[n] = SLOT_W'(p);
			if (size_of[cur] > 0) size_of[cur]--;
			if (size_of[t] == 0) begin
				head_of[t] = SLOT_W'(s);
				prev_slot[s] = SLOT_W'(s);
			end else begin
				next_slot[tail_of[t]] = SLOT_W'(s);
				prev_slot[s] = tail_of[t];
			end
			next_slot[s] = SLOT_W'(s);
			tail_of[t] = SLOT_W'(s);
			size_of[t]++;
			slot_state[s] = ST_W'(t);
		endfunction

		// work out the reply to an accepted item and queue it
		function void note_command(cmd_t c);
			rsp_t r;
			int st;
			r = '0;
			st = c.status;
			if (c.func == FUNC_UNUSED) begin
				r.code = RC_OK;
			end else if (st >= NUM_STATES) begin
				r.code = RC_BAD_STATUS;
			end else if (c.func == FUNC_HEAD) begin
				if (size_of[st] == 0) begin
					r.code = RC_EMPTY;
					r.empty = 1'b1;
				end else begin
					r.code = RC_OK;
					r.head = HEAD_W'(head_of[st]);
					r.count = COUNT_W'(size_of[st]);
				end
			end else if (c.func == FUNC_QUERY) begin
				r.code = RC_OK;
				r.count = COUNT_W'(size_of[st]);
				r.empty = (size_of[st] == 0);
			end else if (c.slot >= NUM_TASKS) begin
				r.code = RC_BAD_SLOT;
			end else begin
				relink(c.slot, st);
				r.code = RC_OK;
				r.count = COUNT_W'(size_of[st]);
				r.empty = (size_of[st] == 0);
			end
			pending_replies.push_back(r);
		endfunction

		// compare a reply from the block with the oldest prediction
		function void check_reply(rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: reply with none expected: code %0d head %0d count %0d empty %0d",
						$realtime, got.code, got.head, got.count, got.empty);
				return;
			end
			want = pending_replies.pop_front();
			if (got.code !== want.code || got.head !== want.head ||
					got.count !== want.count || got.empty !== want.empty) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: reply mismatch: expected code %0d head %0d count %0d empty %0d, got code %0d head %0d count %0d empty %0d",
						$realtime, want.code, want.head, want.count, want.empty,
						got.code, got.head, got.count, got.empty);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [STATUS_W-1:0] list_status;
	logic [INDEX_W-1:0]  slot_index;
	logic                done;
	logic [RC_W-1:0]     result_code;
	logic [HEAD_W-1:0]   head_slot;
	logic [COUNT_W-1:0]  list_count;
	logic                empty_flag;

	slot_list_shadow shadow = new();

	task_state_list_manager uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.list_status(list_status),
		.slot_index (slot_index),
		.done       (done),
		.result_code(result_code),
		.head_slot  (head_slot),
		.list_count (list_count),
		.empty_flag (empty_flag)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// monitor: values read here are the ones held before the edge
	// a reply always belongs to an earlier item, so it is checked first
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.check_reply(rsp_t'{code: result_code, head: head_slot,
					count: list_count, empty: empty_flag});
			if (start && !busy)
				shadow.note_command(cmd_t'{func: func, status: list_status, slot: slot_index});
		end
	end

	// one cycle with start low; the fields carry noise that must be ignored
	task idle_cycle();
		@(negedge clk);
		start <= 1'b0;
		func <= FUNC_W'($urandom);
		list_status <= STATUS_W'($urandom);
		slot_index <= INDEX_W'($urandom);
	endtask

	// present one item and hold it until the block takes it
	task send_item(input logic [FUNC_W-1:0] f, input logic [STATUS_W-1:0] s,
			input logic [INDEX_W-1:0] i);
		@(negedge clk);
		start <= 1'b1;
		func <= f;
		list_status <= s;
		slot_index <= i;
		do @(posedge clk); while (busy);
	endtask

	// random item: mostly legal moves to keep the lists churning, some lookups, some noise
	task send_random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			send_item(FUNC_MOVE, STATUS_W'($urandom_range(NUM_STATES - 1)),
				INDEX_W'($urandom_range(NUM_TASKS - 1)));
		else if (pick < 75)
			send_item(FUNC_HEAD, STATUS_W'($urandom_range(NUM_STATES - 1)), INDEX_W'($urandom));
		else if (pick < 85)
			send_item(FUNC_QUERY, STATUS_W'($urandom_range(NUM_STATES - 1)), INDEX_W'($urandom));
		else
			// whole field ranges: unused func, bad status, bad slot
			send_item(FUNC_W'($urandom), STATUS_W'($urandom), INDEX_W'($urandom));
	endtask

	initial begin
		int idle_pct [3];
		int gap;
		int waited;
		idle_pct = '{0, 85, 30};

		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_HEAD;
		list_status = '0;
		slot_index = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, back to back
		send_item(FUNC_QUERY, 3'd0, 5'd0);    // full idle list
		send_item(FUNC_HEAD, 3'd0, 5'd0);     // idle head is slot 0
		send_item(FUNC_HEAD, 3'd1, 5'd0);     // head of an empty list
		send_item(FUNC_QUERY, 3'd3, 5'd0);    // empty list query
		send_item(FUNC_UNUSED, 3'd7, 5'd31);  // unused func answers all zero
		send_item(FUNC_HEAD, 3'd4, 5'd0);     // bad status on head
		send_item(FUNC_QUERY, 3'd7, 5'd0);    // bad status on query
		send_item(FUNC_MOVE, 3'd5, 5'd31);    // status checked before slot
		send_item(FUNC_MOVE, 3'd2, 5'd16);    // bad slot, lowest
		send_item(FUNC_MOVE, 3'd1, 5'd31);    // bad slot, highest
		send_item(FUNC_MOVE, 3'd1, 5'd0);     // idle head into an empty list
		send_item(FUNC_MOVE, 3'd1, 5'd15);    // idle tail, list one grows
		send_item(FUNC_MOVE, 3'd1, 5'd7);     // middle of the idle list
		send_item(FUNC_MOVE, 3'd0, 5'd3);     // own status, middle slot goes to tail
		send_item(FUNC_MOVE, 3'd1, 5'd0);     // own status, head slot goes to tail
		send_item(FUNC_MOVE, 3'd1, 5'd0);     // own status, already the tail
		send_item(FUNC_HEAD, 3'd1, 5'd0);
		send_item(FUNC_MOVE, 3'd3, 5'd10);    // highest status, empty target
		send_item(FUNC_MOVE, 3'd3, 5'd10);    // own status, only slot in its list
		send_item(FUNC_MOVE, 3'd2, 5'd10);    // leaves list three empty
		send_item(FUNC_QUERY, 3'd3, 5'd0);
		send_item(FUNC_HEAD, 3'd2, 5'd0);
		send_item(FUNC_UNUSED, 3'd0, 5'd0);
		send_item(FUNC_HEAD, 3'd6, 5'd21);

		// random part in phases of sender idling
		foreach (idle_pct[ph]) begin
			for (int n = 0; n < 284; n++) begin
				gap = 0;
				while ($urandom_range(99) < idle_pct[ph] && gap < 60) begin
					idle_cycle();
					gap++;
				end
				send_random_item();
			end
		end
		@(negedge clk);
		start <= 1'b0;

		// drain: a reply comes once its item has passed the command and result registers, so a short limit suffices
		waited = 0;
		while (shadow.pending_replies.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (5) @(posedge clk);

		if (shadow.pending_replies.size() != 0)
			$display("replies never seen: %0d", shadow.pending_replies.size());
		if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
			$display("task_state_list_manager_tb: done, clean");
		end else begin
			$display("task_state_list_manager_tb: done, errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("task_state_list_manager_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
